// ===== src/sipq_pkg.sv =====
`timescale 1ns / 1ps

package sipq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_BITS      = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int STATUS_BITS   = 2;
    localparam int FILL_BITS     = 5;

    // request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                    kind;
        logic [KEY_BITS-1:0]     entry_key;
        logic [PAYLOAD_BITS-1:0] entry_payload;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [KEY_BITS-1:0]     head_key;
        logic [PAYLOAD_BITS-1:0] head_payload;
        logic [FILL_BITS-1:0]    fill_count;
    } rsp_t;

    // one stored entry
    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;    // insert that goes ahead
        logic   rem;    // remove that goes ahead
        entry_t fresh;  // entry being inserted
    } cell_ctrl_t;

endpackage

// ===== src/sipq_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted row.
module sipq_cell
(
    input  logic                clk,
    input  sipq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,   // slot holds a live entry
    input  logic                at_tail,    // first free slot
    input  logic                left_gt,    // left neighbour key > new key
    input  sipq_pkg::entry_t    left_entry,
    input  sipq_pkg::entry_t    right_entry,
    output logic                gt,
    output sipq_pkg::entry_t    entry
);

    sipq_pkg::entry_t entry_reg;
    sipq_pkg::entry_t entry_next;

    assign gt    = occupied && (entry_reg.key > ctrl.fresh.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;      // shift away from head
            end
            else if (gt || at_tail)
            begin
                entry_next = ctrl.fresh;      // insertion point
            end
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;         // shift towards head
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/sorted_insert_priority_queue_core.sv =====
`timescale 1ns / 1ps

// Sorted priority queue of up to DEPTH entries (key + payload), ordered by
// key with the smallest at the head; equal keys leave first-in first-out.
// Each request item (insert or remove) gives exactly one result item with a
// status, the removed head on a successful remove, and the fill count after
// the step. Inserting when full or removing when empty reports a status and
// leaves the queue untouched. The entries live in a row of cells; every cell
// compares its key with the incoming one in parallel and shifts, loads or
// holds, so every cell of the row is updated in the same cycle. Throughput is
// one item per cycle unless a stalled result stalls new requests; the
// result is held in an output register from the cycle after acceptance.
module sorted_insert_priority_queue_core
#(
    parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sipq_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sipq_pkg::rsp_t  rsp
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             rsp_valid_reg;
    sipq_pkg::rsp_t   rsp_reg;
    sipq_pkg::rsp_t   rsp_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    sipq_pkg::cell_ctrl_t ctrl;

    logic             [DEPTH-1:0] cell_gt;
    sipq_pkg::entry_t             cell_entry [DEPTH];
    logic             [OCC_W+sipq_pkg::FILL_BITS-1:0] fill_wide;

    // Result register frees up when taken, so one item per cycle flows.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full  = (occ_reg == OCC_W'(DEPTH));
    assign empty = (occ_reg == '0);

    always_comb
    begin
        ctrl.ins           = accept && (req.kind == sipq_pkg::KIND_INSERT) && !full;
        ctrl.rem           = accept && (req.kind == sipq_pkg::KIND_REMOVE) && !empty;
        ctrl.fresh.key     = req.entry_key;
        ctrl.fresh.payload = req.entry_payload;
    end

    // Row of cells; head at index 0.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             left_gt;
        sipq_pkg::entry_t left_entry;
        sipq_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_gt    = 1'b0;
            assign left_entry = ctrl.fresh;
        end
        else
        begin : g_mid
            assign left_gt    = cell_gt[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        sipq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ_reg > OCC_W'(i)),
            .at_tail     (occ_reg == OCC_W'(i)),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .gt          (cell_gt[i]),
            .entry       (cell_entry[i])
        );
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (ctrl.ins)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (ctrl.rem)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    assign fill_wide = {{sipq_pkg::FILL_BITS{1'b0}}, occ_next};

    always_comb
    begin
        rsp_next.status       = sipq_pkg::ST_DONE;
        rsp_next.head_key     = '0;
        rsp_next.head_payload = '0;
        rsp_next.fill_count   = fill_wide[sipq_pkg::FILL_BITS-1:0];
        if (req.kind == sipq_pkg::KIND_INSERT)
        begin
            if (full)
            begin
                rsp_next.status = sipq_pkg::ST_FULL;
            end
        end
        else if (empty)
        begin
            rsp_next.status = sipq_pkg::ST_EMPTY;
        end
        else
        begin
            rsp_next.head_key     = cell_entry[0].key;
            rsp_next.head_payload = cell_entry[0].payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Occupancy never runs past the row.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    // An accepted item always leaves a result behind.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("result missing after accept");

    // Empty refusal only when nothing is stored.
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == sipq_pkg::ST_EMPTY) |-> (rsp.fill_count == '0))
        else $error("empty status with entries stored");

    // Queue contents change only on an accepted item.
    a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(occ_reg))
        else $error("occupancy moved without an item");

endmodule
